FILE: rtl/bse_pkg.sv
// shared widths, reset values and sequencer state type for the bitonic sort engine
`default_nettype none

package bse_pkg;

    localparam int VALUE_W = 32;
    localparam int LOG_W   = 3;

    localparam logic [LOG_W-1:0] LOG_COUNT_RESET = 3'd6;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_READ = 6'b000010,
        S_CMP  = 6'b000100,
        S_WR   = 6'b001000,
        S_PRE  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/bse_if.sv
// valid/ready channel interfaces: value input, sorted output and configuration write
`default_nettype none

interface bse_in_if;
    import bse_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bse_out_if;
    import bse_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] sorted_value;
    logic               last_out;

    modport source (output valid, output sorted_value, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

interface bse_cfg_if;
    import bse_pkg::*;

    logic             valid;
    logic             ready;
    logic [LOG_W-1:0] log_count;

    modport source (output valid, output log_count, input ready);
    modport sink   (input valid, input log_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/bse_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/bitonic_sort_engine_top.sv
// bitonic sort engine: block load, shared compare-exchange sequencer, sorted emit
//
//  channel   dir  handshake     beat carries
//  i_cfg     in   valid/ready   log_count (block size 2^log_count, capped at the largest power of two <= MAX_ELEMENTS)
//  i_in      in   valid/ready   value, one per beat, n beats per block
//  o_out     out  valid/ready   sorted_value, last_out on the final beat of the block
//
//  load takes one beat a cycle; the last beat of a block starts the sort
//  the sort runs one compare-exchange at a time on a dual-read copy of the store:
//  each pair is read then compared (READ, CMP), with a WR step added when the pair
//  swaps (one write port); (n/2)*log2(n)*(log2(n)+1)/2 pairs per block; then a PRE
//  setup step and one beat a cycle out while o_out is not stalled; i_in and i_cfg
//  are not ready from the last beat of a block until the final result is registered
//  synchronous active-low reset returns to load with log_count 6 and an empty block
//  o_out stalls hold the emit sequencer; the output register parts the two sides
`default_nettype none

module bitonic_sort_engine_top #(
    parameter int MAX_ELEMENTS = 64
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    bse_cfg_if.sink   i_cfg,
    bse_in_if.sink    i_in,
    bse_out_if.source o_out
);
    import bse_pkg::*;

    localparam int LOG_MAX = $clog2(MAX_ELEMENTS + 1) - 1;
    localparam int IW      = LOG_MAX;
    localparam int NW      = LOG_MAX + 1;
    localparam int AW      = $clog2(MAX_ELEMENTS);
    localparam logic [NW-1:0] N_MAX = NW'(1) << LOG_MAX;

    t_state             r_state, n_state;
    logic [LOG_W-1:0]   r_log_count, n_log_count;
    logic [IW-1:0]      r_load_cnt, n_load_cnt;
    logic [NW-1:0]      r_k, n_k;
    logic [IW-1:0]      r_j, n_j;
    logic [IW-1:0]      r_p, n_p;
    logic [IW-1:0]      r_e, n_e;
    logic [VALUE_W-1:0] r_a, n_a;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_value, n_out_value;
    logic               r_out_last, n_out_last;

    logic [NW-1:0]      w_n;
    logic [NW-1:0]      w_n_m1;
    logic [NW-1:0]      w_half_m1;
    logic [IW-1:0]      w_mask;
    logic [IW-1:0]      w_i;
    logic [IW-1:0]      w_l;
    logic               w_up;
    logic               w_swap;
    logic               w_slot;
    logic               w_adv;
    logic               w_in_fire;
    logic               w_cfg_fire;

    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [VALUE_W-1:0] w_wr_data;
    logic [AW-1:0]      w_rd_addr0;
    logic [VALUE_W-1:0] w_q0;
    logic [VALUE_W-1:0] w_q1;

    // block size, saturated to the largest power of two the store holds
    assign w_n       = (int'(r_log_count) > LOG_MAX) ? N_MAX : (NW'(1) << r_log_count);
    assign w_n_m1    = w_n - NW'(1);
    assign w_half_m1 = (w_n >> 1) - NW'(1);

    // pair index p -> lower element i (zero inserted at the bit of j), partner l
    assign w_mask = r_j - IW'(1);
    assign w_i    = ((r_p & ~w_mask) << 1) | (r_p & w_mask);
    assign w_l    = w_i | r_j;
    assign w_up   = (({1'b0, w_i} & r_k) == '0);
    assign w_swap = w_up ? (w_q0 > w_q1) : (w_q0 < w_q1);

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;
    assign w_slot     = !r_out_valid || o_out.ready;
    assign w_adv      = ((r_state == S_CMP) && !w_swap) || (r_state == S_WR);

    assign i_cfg.ready        = (r_state == S_LOAD);
    assign i_in.ready         = (r_state == S_LOAD);
    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.last_out     = r_out_last;

    // store write port: load beat, low half of a swap, high half of a swap
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = AW'(r_load_cnt);
        w_wr_data = i_in.value;
        unique case (r_state)
            S_LOAD: begin
                w_wr_en = w_in_fire;
            end
            S_CMP: begin
                w_wr_en   = w_swap;
                w_wr_addr = AW'(w_i);
                w_wr_data = w_q1;
            end
            S_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = AW'(w_l);
                w_wr_data = r_a;
            end
            S_READ, S_PRE, S_EMIT: begin
                w_wr_en = 1'b0;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_PRE:   w_rd_addr0 = AW'(r_e);
            S_EMIT:  w_rd_addr0 = w_slot ? AW'(r_e + IW'(1)) : AW'(r_e);
            default: w_rd_addr0 = AW'(w_i);
        endcase
    end

    // two copies written alike give the two read ports a compare-exchange needs
    bse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram_lo (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr0),
        .o_rd_data (w_q0)
    );

    bse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram_hi (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (AW'(w_l)),
        .o_rd_data (w_q1)
    );

    always_comb begin
        n_state     = r_state;
        n_log_count = r_log_count;
        n_load_cnt  = r_load_cnt;
        n_k         = r_k;
        n_j         = r_j;
        n_p         = r_p;
        n_e         = r_e;
        n_a         = r_a;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                if (w_in_fire) begin
                    if (r_load_cnt == w_n_m1[IW-1:0]) begin
                        n_load_cnt = '0;
                        n_k        = NW'(2);
                        n_j        = IW'(1);
                        n_p        = '0;
                        n_e        = '0;
                        n_state    = (w_n == NW'(1)) ? S_PRE : S_READ;
                    end else begin
                        n_load_cnt = r_load_cnt + IW'(1);
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_a = w_q0;
                if (w_swap) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                n_state = S_READ;
            end
            S_PRE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_value = w_q0;
                    n_out_last  = (r_e == w_n_m1[IW-1:0]);
                    if (r_e == w_n_m1[IW-1:0]) begin
                        n_state = S_LOAD;
                    end else begin
                        n_e = r_e + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // step to the next pair, then next distance, then next stage size
        if (w_adv) begin
            n_state = S_READ;
            if (r_p == w_half_m1[IW-1:0]) begin
                n_p = '0;
                if (r_j == IW'(1)) begin
                    if (r_k == w_n) begin
                        n_state = S_PRE;
                    end else begin
                        n_k = r_k << 1;
                        n_j = r_k[IW-1:0];
                    end
                end else begin
                    n_j = r_j >> 1;
                end
            end else begin
                n_p = r_p + IW'(1);
            end
        end

        // a log_count write drops any partial block
        if (w_cfg_fire) begin
            n_log_count = i_cfg.log_count;
            n_load_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_log_count <= LOG_COUNT_RESET;
            r_load_cnt  <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_p         <= '0;
            r_e         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_log_count <= n_log_count;
            r_load_cnt  <= n_load_cnt;
            r_k         <= n_k;
            r_j         <= n_j;
            r_p         <= n_p;
            r_e         <= n_e;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

endmodule

`default_nettype wire

FILE: rtl/bse_checker.sv
// port-level checks on the bitonic sort engine, bound to the top level
`default_nettype none

module bse_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_out_value,
    input wire        i_out_last
);
    import bse_pkg::*;

    logic               r_have;
    logic               r_prev_last;
    logic [VALUE_W-1:0] r_prev;
    logic               w_out_fire;

    assign w_out_fire = i_out_valid && i_out_ready;

    // last beat seen on the output, to check ascending order within a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_prev_last <= 1'b0;
        end else if (w_out_fire) begin
            r_have      <= 1'b1;
            r_prev_last <= i_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire) begin
            r_prev <= i_out_value;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_last))
        else $error("stalled output beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid straight after reset");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && r_have && !r_prev_last |-> i_out_value >= r_prev)
        else $error("sorted block out of order");

    a_no_load_mid_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready while a block is still being emitted");

endmodule

bind bitonic_sort_engine_top bse_checker u_bse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.sorted_value),
    .i_out_last  (o_out.last_out)
);

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for the bitonic sort engine: block loads, sorted beats, size changes
`timescale 1ns / 100ps

typedef struct packed {
    logic [bse_pkg::VALUE_W-1:0] value;
    logic                        last;
} t_sorted_beat;

class sorted_block_checker;
    int unsigned                 cap;
    logic [bse_pkg::LOG_W-1:0]   log_count;
    logic [bse_pkg::VALUE_W-1:0] block[$];
    t_sorted_beat                sorted_due[$];
    int                          errors;

    function new(int unsigned max_elements);
        cap       = max_elements;
        log_count = bse_pkg::LOG_COUNT_RESET;
        errors    = 0;
    endfunction

    // block size saturates at the store depth
    function int unsigned block_len();
        int unsigned n;
        n = 1 << log_count;
        while (n > 1 && n > cap) n = n >> 1;
        return n;
    endfunction

    // a size change drops whatever partial block is held
    function void write_log_count(logic [bse_pkg::LOG_W-1:0] lc);
        log_count = lc;
        block.delete();
    endfunction

    function void bitonic_order();
        int unsigned                 n, k, j, i, p;
        logic [bse_pkg::VALUE_W-1:0] a, b;
        bit                          up;
        n = block.size();
        for (k = 2; k <= n; k = k << 1) begin
            for (j = k >> 1; j > 0; j = j >> 1) begin
                for (i = 0; i < n; i++) begin
                    p = i ^ j;
                    if (p > i && p < n) begin
                        a  = block[i];
                        b  = block[p];
                        up = ((i & k) == 0);
                        if (up ? (a > b) : (a < b)) begin
                            block[i] = b;
                            block[p] = a;
                        end
                    end
                end
            end
        end
    endfunction

    function void load_value(logic [bse_pkg::VALUE_W-1:0] v);
        t_sorted_beat beat;
        int unsigned  n;
        block.push_back(v);
        n = block_len();
        if (block.size() == n) begin
            bitonic_order();
            foreach (block[i]) begin
                beat.value = block[i];
                beat.last  = (i == n - 1);
                sorted_due.push_back(beat);
            end
            block.delete();
        end
    endfunction

    function void flag(string what);
        errors++;
        if (errors <= 10) $display("%0t mismatch: %s", $realtime, what);
    endfunction

    function void check_beat(logic [bse_pkg::VALUE_W-1:0] v, logic last);
        t_sorted_beat want;
        if (sorted_due.size() == 0) begin
            flag($sformatf("unexpected beat value %08h last %0b", v, last));
            return;
        end
        want = sorted_due.pop_front();
        if (want.value !== v || want.last !== last)
            flag($sformatf("expected value %08h last %0b, got value %08h last %0b",
                           want.value, want.last, v, last));
    endfunction

    function int outstanding();
        return sorted_due.size();
    endfunction
endclass

module testbench;
    import bse_pkg::*;

    localparam int MAX_ELEMENTS = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam int QUIET_LIMIT  = 20000;

    logic clk;
    logic rst_n;

    bse_cfg_if cfg_ch ();
    bse_in_if  in_ch ();
    bse_out_if out_ch ();

    bitonic_sort_engine_top #(.MAX_ELEMENTS(MAX_ELEMENTS)) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sorted_block_checker scoreboard;

    int tx_gap_pct;
    int rx_stall_pct;
    bit hold_go;
    bit hold_taken;
    int hold_left;
    int quiet_cycles;
    bit moved;

    always #4 clk = ~clk;

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // beat monitor and watchdog
    always @(posedge clk) begin
        moved = 1'b0;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                scoreboard.write_log_count(cfg_ch.log_count);
                moved = 1'b1;
            end
            if (in_ch.valid && in_ch.ready) begin
                scoreboard.load_value(in_ch.value);
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                scoreboard.check_beat(out_ch.sorted_value, out_ch.last_out);
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom_range(0, 3);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high between back-to-back beats
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic set_log_count(input logic [LOG_W-1:0] lc);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.log_count <= lc;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (scoreboard.outstanding() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // full blocks of random data, then a short partial block that the next size change drops
    task automatic run_phase(input logic [LOG_W-1:0] lc, input int blocks, input bit squeeze);
        int unsigned len;
        int unsigned spare;
        drain();
        set_log_count(lc);
        len = scoreboard.block_len();
        if (squeeze) hold_go = 1'b1;
        repeat (blocks * len) send_value(rand_value());
        spare = (len > 1) ? $urandom_range(0, (len > 4) ? 3 : len - 1) : 0;
        repeat (spare) send_value(rand_value());
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.log_count = '0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        out_ch.ready     = 1'b0;
        tx_gap_pct       = 24;
        rx_stall_pct     = 52;
        hold_go          = 1'b0;
        hold_taken       = 1'b0;
        hold_left        = 0;
        quiet_cycles     = 0;
        scoreboard       = new(MAX_ELEMENTS);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // partial block at the reset size, dropped by the size change
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_0001);
        in_ch.valid <= 1'b0;
        drain();

        // single-value blocks come straight back marked last
        set_log_count(3'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_0000);
        send_value(32'h8000_0000);
        in_ch.valid <= 1'b0;
        drain();

        set_log_count(3'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_0000);
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_0005);
        send_value(32'h0000_0005);
        in_ch.valid <= 1'b0;
        drain();

        // sign bit must not matter, then duplicates
        set_log_count(3'd2);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_0000);
        send_value(32'h0000_0007);
        send_value(32'h0000_0007);
        send_value(32'h0000_0003);
        send_value(32'h0000_0007);
        send_value(32'hA5A5_A5A5);
        send_value(32'h5A5A_5A5A);
        in_ch.valid <= 1'b0;

        tx_gap_pct   = 24;
        rx_stall_pct = 52;
        run_phase(3'd3, 2, 1'b0);
        run_phase(3'd7, 1, 1'b0);

        tx_gap_pct   = 52;
        rx_stall_pct = 24;
        run_phase(3'd1, 4, 1'b0);
        run_phase(3'd4, 2, 1'b0);
        run_phase(3'd5, 1, 1'b0);

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        run_phase(3'd0, 6, 1'b0);
        run_phase(3'd2, 4, 1'b1);
        run_phase(3'd3, 2, 1'b0);

        drain();
        if (scoreboard.errors == 0 && scoreboard.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
